### hdl/spm_pkg.sv
package spm_pkg;

	localparam int unsigned MASK_W = 32;
	localparam int unsigned STRIDE_W = 6;
	localparam int unsigned CPU_W = 5;
	localparam int unsigned COUNT_W = 6;
	localparam int unsigned PLACE_W = 7;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_MASK = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_STRIDE = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_USE_SLOT = 2'd2;

	localparam logic [CPU_W-1:0] COUNT_LAST = CPU_W'(MASK_W / DIGIT_W - 1);
	localparam logic [CPU_W-1:0] DIVIDE_LAST = CPU_W'(MASK_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COUNT,
		ST_DIVIDE,
		ST_WALK,
		ST_SCAN,
		ST_EMIT
	} spm_state_t;

	function automatic logic [2:0] popcount_digit(input logic [DIGIT_W-1:0] d);
		logic [2:0] s;
		s = 3'd0;
		for (int k = 0; k < DIGIT_W; k++) begin
			s = s + {2'b00, d[k]};
		end
		return s;
	endfunction

endpackage

### hdl/spm_if.sv
interface spm_req_if;
	logic valid;
	logic ready;
	logic [spm_pkg::MASK_W-1:0] slot_index;

	modport source(output valid, output slot_index, input ready);
	modport sink(input valid, input slot_index, output ready);
endinterface

interface spm_rsp_if;
	logic valid;
	logic ready;
	logic [spm_pkg::CPU_W-1:0] cpu_index;
	logic [spm_pkg::CPU_W-1:0] thread_position;
	logic mask_empty;

	modport source(output valid, output cpu_index, output thread_position,
		output mask_empty, input ready);
	modport sink(input valid, input cpu_index, input thread_position,
		input mask_empty, output ready);
endinterface

### hdl/strided_cpu_pinning_mapper_top.sv
// Channel  | Direction | Payload
// ---------+-----------+-------------------------------------------------
// req      | in        | slot_index[31:0]
// rsp      | out       | cpu_index[4:0], thread_position[4:0], mask_empty
// cfg      | in        | cfg_we, cfg_index[1:0], cfg_data[31:0]
//
// One item is processed at a time; an empty mask skips the divide, walk and
// search steps. The mask is counted four bits per cycle, the thread number is
// reduced by a radix-2 restoring divider, the stride walk steps through the
// positions and the set-bit search inspects one mask bit per cycle.
// Reset is asynchronous and active low and restores the configuration and counter.
// A new item is accepted while a finished result waits in the output register.
module strided_cpu_pinning_mapper_top (
	input  logic clk,
	input  logic arst_n,
	spm_req_if.sink req,
	spm_rsp_if.source rsp,
	input  logic cfg_we,
	input  logic [spm_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [spm_pkg::MASK_W-1:0] cfg_data
);

	spm_pkg::spm_state_t state_q, state_nxt;

	logic [spm_pkg::MASK_W-1:0] mask_q;
	logic [spm_pkg::STRIDE_W-1:0] stride_q;
	logic use_slot_q;
	logic [spm_pkg::MASK_W-1:0] counter_q;

	logic [spm_pkg::MASK_W-1:0] thr_q;
	logic [spm_pkg::MASK_W-1:0] msk_sh_q;
	logic [spm_pkg::COUNT_W-1:0] n_q;
	logic [spm_pkg::CPU_W-1:0] iter_q;
	logic [spm_pkg::CPU_W-1:0] rem_q;
	logic [spm_pkg::CPU_W-1:0] steps_q;
	logic [spm_pkg::CPU_W-1:0] place_q;
	logic [spm_pkg::CPU_W-1:0] offset_q;
	logic [spm_pkg::CPU_W-1:0] cpu_q;
	logic empty_q;

	logic out_valid_q;
	logic [spm_pkg::CPU_W-1:0] out_cpu_q;
	logic [spm_pkg::CPU_W-1:0] out_pos_q;
	logic out_empty_q;

	logic in_ready;
	logic ld_out;
	logic accept;
	logic [spm_pkg::COUNT_W-1:0] n_sum;
	logic [spm_pkg::COUNT_W-1:0] trial;
	logic [spm_pkg::COUNT_W-1:0] trial_diff;
	logic [spm_pkg::CPU_W-1:0] rem_nxt;
	logic [spm_pkg::PLACE_W-1:0] walk_sum;
	logic [spm_pkg::CPU_W-1:0] offset_inc;
	logic found;

	assign accept = req.valid && in_ready;
	assign req.ready = in_ready;

	assign n_sum = n_q + {3'b000,
		spm_pkg::popcount_digit(msk_sh_q[spm_pkg::DIGIT_W-1:0])};
	assign trial = {rem_q, thr_q[spm_pkg::MASK_W-1]};
	assign trial_diff = trial - n_q;
	assign rem_nxt = (trial >= n_q) ? trial_diff[spm_pkg::CPU_W-1:0]
		: trial[spm_pkg::CPU_W-1:0];
	assign walk_sum = {2'b00, place_q} + {1'b0, stride_q};
	assign offset_inc = offset_q + 5'd1;
	assign found = msk_sh_q[0] && (place_q == '0);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			spm_pkg::ST_IDLE: begin
				if (req.valid) state_nxt = spm_pkg::ST_COUNT;
			end
			spm_pkg::ST_COUNT: begin
				if (iter_q == spm_pkg::COUNT_LAST) begin
					state_nxt = (n_sum == '0) ? spm_pkg::ST_EMIT : spm_pkg::ST_DIVIDE;
				end
			end
			spm_pkg::ST_DIVIDE: begin
				if (iter_q == spm_pkg::DIVIDE_LAST) state_nxt = spm_pkg::ST_WALK;
			end
			spm_pkg::ST_WALK: begin
				if (steps_q == '0) state_nxt = spm_pkg::ST_SCAN;
			end
			spm_pkg::ST_SCAN: begin
				if (found) state_nxt = spm_pkg::ST_EMIT;
			end
			spm_pkg::ST_EMIT: begin
				if (ld_out) state_nxt = spm_pkg::ST_IDLE;
			end
			default: state_nxt = spm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ld_out = 1'b0;
		case (state_q)
			spm_pkg::ST_IDLE: in_ready = 1'b1;
			spm_pkg::ST_EMIT: ld_out = !out_valid_q || rsp.ready;
			default: begin
				in_ready = 1'b0;
				ld_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spm_pkg::ST_IDLE;
			mask_q <= '1;
			stride_q <= spm_pkg::STRIDE_W'(1);
			use_slot_q <= 1'b0;
			counter_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				case (cfg_index)
					spm_pkg::REG_MASK: mask_q <= cfg_data;
					spm_pkg::REG_STRIDE: stride_q <= cfg_data[spm_pkg::STRIDE_W-1:0];
					spm_pkg::REG_USE_SLOT: use_slot_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (accept && !use_slot_q) counter_q <= counter_q + 32'd1;
			if (ld_out) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			spm_pkg::ST_IDLE: begin
				thr_q <= use_slot_q ? req.slot_index : counter_q;
				msk_sh_q <= mask_q;
				n_q <= '0;
				rem_q <= '0;
				iter_q <= '0;
			end
			spm_pkg::ST_COUNT: begin
				n_q <= n_sum;
				if (iter_q == spm_pkg::COUNT_LAST) begin
					msk_sh_q <= mask_q;
					iter_q <= '0;
					empty_q <= (n_sum == '0);
				end else begin
					iter_q <= iter_q + 5'd1;
					msk_sh_q <= msk_sh_q >> spm_pkg::DIGIT_W;
				end
			end
			spm_pkg::ST_DIVIDE: begin
				rem_q <= rem_nxt;
				thr_q <= thr_q << 1;
				iter_q <= iter_q + 5'd1;
				steps_q <= rem_nxt;
				place_q <= '0;
				offset_q <= '0;
			end
			spm_pkg::ST_WALK: begin
				if (steps_q != '0) begin
					steps_q <= steps_q - 5'd1;
					if (walk_sum >= {1'b0, n_q}) begin
						offset_q <= offset_inc;
						place_q <= offset_inc;
					end else begin
						place_q <= walk_sum[spm_pkg::CPU_W-1:0];
					end
				end
			end
			spm_pkg::ST_SCAN: begin
				msk_sh_q <= msk_sh_q >> 1;
				iter_q <= iter_q + 5'd1;
				if (found) cpu_q <= iter_q;
				else if (msk_sh_q[0]) place_q <= place_q - 5'd1;
			end
			spm_pkg::ST_EMIT: begin
				if (ld_out) begin
					out_cpu_q <= empty_q ? '0 : cpu_q;
					out_pos_q <= empty_q ? '0 : rem_q;
					out_empty_q <= empty_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid = out_valid_q;
	assign rsp.cpu_index = out_cpu_q;
	assign rsp.thread_position = out_pos_q;
	assign rsp.mask_empty = out_empty_q;

endmodule

### hdl/spm_checker.sv
module spm_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [spm_pkg::CPU_W-1:0] rsp_cpu_index,
	input logic [spm_pkg::CPU_W-1:0] rsp_thread_position,
	input logic rsp_mask_empty
);

	// The block works on one item at a time, so it is busy right after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("input accepted while an item is still in work");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("result appeared one cycle after acceptance");

	a_empty_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_mask_empty |-> rsp_cpu_index == '0 && rsp_thread_position == '0)
		else $error("empty-mask result carries nonzero fields");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cpu_index)
			&& $stable(rsp_thread_position) && $stable(rsp_mask_empty))
		else $error("stalled result changed");

endmodule

bind strided_cpu_pinning_mapper_top spm_checker u_spm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_cpu_index(rsp.cpu_index),
	.rsp_thread_position(rsp.thread_position),
	.rsp_mask_empty(rsp.mask_empty)
);
